FILE: rtl/dual_channel_frame_receiver_crc16_assert.svh
// Assertion macros used by the receiver back end.
// Both macros sample on the rising clock edge and are disabled during reset.
`ifndef DUAL_CHANNEL_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define DUAL_CHANNEL_FRAME_RECEIVER_CRC16_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define DCFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("receiver assertion failed");

// The condition must hold in the cycle after the trigger.
`define DCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("receiver assertion failed");

`endif

FILE: rtl/dcfr_pkg.sv
package dcfr_pkg;

  // Operation codes, equal to the kind field of an input transaction.
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CRCL  = 3'd5,
    PH_CRCH  = 3'd6
  } phase_t;

  localparam logic [7:0]  SYNC_FIRST  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND = 8'hAA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [1:0]  LOCK_NONE   = 2'd0;
  localparam int          QUEUE_DEPTH = 2;

  // A decoded transaction as it travels from the front end to the back end.
  typedef struct packed {
    op_t        op;
    logic       chan_present;
    logic       chan;
    logic [7:0] data;
    logic       idx_ok;
    logic [6:0] idx;
  } cmd_t;

  // What one deframer lane reports to the back end.
  typedef struct packed {
    logic       good;
    logic       wr_en;
    logic [7:0] wr_off;
    logic [7:0] command;
    logic [7:0] length;
  } lane_stat_t;

  // One byte of CRC-16/MODBUS, reflected, bit by bit.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/dcfr_in_if.sv
interface dcfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       channel;
  logic [7:0] data_byte;
  logic [6:0] read_index;

  modport source (output valid, output kind, output channel, output data_byte,
                  output read_index, input ready);
  modport sink (input valid, input kind, input channel, input data_byte,
                input read_index, output ready);
endinterface

FILE: rtl/dcfr_out_if.sv
interface dcfr_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        frame_held;
  logic [1:0]  locked_channel;
  logic [7:0]  frame_command;
  logic [7:0]  frame_length;
  logic [7:0]  read_data;
  logic [31:0] received_total;

  modport source (output valid, output accepted, output frame_held,
                  output locked_channel, output frame_command, output frame_length,
                  output read_data, output received_total, input ready);
  modport sink (input valid, input accepted, input frame_held,
                input locked_channel, input frame_command, input frame_length,
                input read_data, input received_total, output ready);
endinterface

FILE: rtl/dcfr_front.sv
module dcfr_front
  import dcfr_pkg::*;
#(
  parameter int PAYLOAD_MAX   = 128,
  parameter int CHANNEL_COUNT = 2
) (
  input  logic       clk,
  input  logic       rst,
  dcfr_in_if.sink    req,
  output logic       push_valid,
  output cmd_t       push_cmd,
  input  logic       push_ready
);

  logic f_valid;
  logic f_valid_next;
  cmd_t f_cmd;
  logic take;

  // The decode register drains into the queue while a new transaction lands.
  assign req.ready = !f_valid || push_ready;
  assign take      = req.valid && req.ready;

  always_comb begin
    f_valid_next = f_valid;
    if (take) begin
      f_valid_next = 1'b1;
    end else if (push_ready) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_cmd.op           <= op_t'(req.kind);
      f_cmd.chan_present <= (32'(req.channel) < CHANNEL_COUNT);
      f_cmd.chan         <= req.channel;
      f_cmd.data         <= req.data_byte;
      f_cmd.idx_ok       <= (32'(req.read_index) < PAYLOAD_MAX);
      f_cmd.idx          <= req.read_index;
    end
  end

  assign push_valid = f_valid;
  assign push_cmd   = f_cmd;

endmodule

FILE: rtl/dcfr_queue.sv
module dcfr_queue
  import dcfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: rtl/dcfr_parser.sv
module dcfr_parser
  import dcfr_pkg::*;
#(
  parameter int PAYLOAD_MAX = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       take,
  input  logic [7:0] data_byte,
  output lane_stat_t stat
);

  localparam logic [7:0] MAX_LEN = 8'(PAYLOAD_MAX);

  phase_t      phase, phase_next;
  logic [7:0]  command, command_next;
  logic [7:0]  length, length_next;
  logic [7:0]  fill_offset, fill_offset_next;
  logic [7:0]  crc_low, crc_low_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  off_inc;
  logic [15:0] crc_upd;

  assign off_inc = fill_offset + 8'd1;
  assign crc_upd = crc_step(crc, data_byte);

  always_comb begin
    phase_next       = phase;
    command_next     = command;
    length_next      = length;
    fill_offset_next = fill_offset;
    crc_low_next     = crc_low;
    crc_next         = crc;
    stat.good        = 1'b0;
    stat.wr_en       = 1'b0;
    stat.wr_off      = fill_offset;
    stat.command     = command;
    stat.length      = length;
    if (take) begin
      unique case (phase)
        PH_SYNC1: begin
          if (data_byte == SYNC_FIRST) begin
            phase_next = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (data_byte == SYNC_SECOND) begin
            phase_next = PH_CMD;
            crc_next   = CRC_INIT;
          end else if (data_byte != SYNC_FIRST) begin
            phase_next = PH_SYNC1;
          end
        end
        PH_CMD: begin
          command_next = data_byte;
          crc_next     = crc_upd;
          phase_next   = PH_LEN;
        end
        PH_LEN: begin
          fill_offset_next = 8'd0;
          if (data_byte > MAX_LEN) begin
            phase_next = PH_SYNC1;
          end else begin
            length_next = data_byte;
            crc_next    = crc_upd;
            phase_next  = (data_byte == 8'd0) ? PH_CRCL : PH_DATA;
          end
        end
        PH_DATA: begin
          stat.wr_en       = (fill_offset < MAX_LEN);
          crc_next         = crc_upd;
          fill_offset_next = off_inc;
          if (off_inc >= length) begin
            phase_next = PH_CRCL;
          end
        end
        PH_CRCL: begin
          crc_low_next = data_byte;
          phase_next   = PH_CRCH;
        end
        PH_CRCH: begin
          phase_next = PH_SYNC1;
          stat.good  = (crc_low == crc[7:0]) && (data_byte == crc[15:8]);
        end
        default: begin
          phase_next = PH_SYNC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase       <= PH_SYNC1;
      command     <= 8'd0;
      length      <= 8'd0;
      fill_offset <= 8'd0;
      crc_low     <= 8'd0;
      crc         <= CRC_INIT;
    end else begin
      phase       <= phase_next;
      command     <= command_next;
      length      <= length_next;
      fill_offset <= fill_offset_next;
      crc_low     <= crc_low_next;
      crc         <= crc_next;
    end
  end

endmodule

FILE: rtl/dcfr_back.sv
`include "dual_channel_frame_receiver_crc16_assert.svh"

module dcfr_back
  import dcfr_pkg::*;
#(
  parameter int PAYLOAD_MAX   = 128,
  parameter int CHANNEL_COUNT = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  dcfr_out_if.source rsp
);

  localparam int DEPTH = CHANNEL_COUNT * PAYLOAD_MAX;
  localparam int AW    = $clog2(DEPTH);

  lane_stat_t               lane_stat [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] lane_take;
  logic                     any_good;
  logic                     adv;
  logic                     is_byte;
  logic                     restart_go;
  logic [1:0]               owner, owner_next;
  logic                     pending, pending_next;
  logic [31:0]              total;
  logic                     r_valid;
  logic                     r_accepted;
  logic                     r_rd_hit;
  logic                     rd_hit;
  logic [7:0]               rd_q;
  logic [7:0]               mem [DEPTH];
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic [7:0]               sel_command;
  logic [7:0]               sel_length;

  // Execute when the result register is free or being emptied this cycle.
  assign adv        = q_valid && (!r_valid || rsp.ready);
  assign q_pop      = adv;
  assign is_byte    = adv && (q_cmd.op == OP_BYTE) && !pending;
  assign restart_go = adv && (q_cmd.op == OP_RESTART);
  assign rd_hit     = (q_cmd.op == OP_READ) && (owner != LOCK_NONE) && q_cmd.idx_ok;

  for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_lane
    assign lane_take[c] = is_byte && q_cmd.chan_present && (q_cmd.chan == 1'(c)) &&
                          ((owner == LOCK_NONE) || (owner == 2'(c + 1)));

    dcfr_parser #(
      .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_parser (
      .clk       (clk),
      .rst       (rst),
      .clear     (restart_go),
      .take      (lane_take[c]),
      .data_byte (q_cmd.data),
      .stat      (lane_stat[c])
    );
  end

  always_comb begin
    any_good    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    rd_addr     = '0;
    sel_command = 8'd0;
    sel_length  = 8'd0;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      if (lane_stat[c].good) begin
        any_good = 1'b1;
      end
      if (lane_stat[c].wr_en) begin
        wr_en   = 1'b1;
        wr_addr = AW'(c * PAYLOAD_MAX) + AW'(lane_stat[c].wr_off);
      end
      if (owner == 2'(c + 1)) begin
        rd_addr     = AW'(c * PAYLOAD_MAX) + AW'(q_cmd.idx);
        sel_command = lane_stat[c].command;
        sel_length  = lane_stat[c].length;
      end
    end
  end

  always_comb begin
    owner_next   = owner;
    pending_next = pending;
    if (adv) begin
      unique case (q_cmd.op)
        OP_BYTE: begin
          if (any_good) begin
            pending_next = 1'b1;
            if (owner == LOCK_NONE) begin
              owner_next = {1'b0, q_cmd.chan} + 2'd1;
            end
          end
        end
        OP_READ: begin
          owner_next = owner;
        end
        OP_RELEASE: begin
          pending_next = 1'b0;
        end
        OP_RESTART: begin
          owner_next   = LOCK_NONE;
          pending_next = 1'b0;
        end
        default: begin
          owner_next = owner;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner   <= LOCK_NONE;
      pending <= 1'b0;
      total   <= 32'd0;
      r_valid <= 1'b0;
    end else begin
      owner   <= owner_next;
      pending <= pending_next;
      if (restart_go) begin
        total <= 32'd0;
      end else if (|lane_take) begin
        total <= total + 32'd1;
      end
      if (adv) begin
        r_valid <= 1'b1;
      end else if (rsp.ready) begin
        r_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_cmd.data;
    end
    if (adv) begin
      rd_q       <= mem[rd_addr];
      r_accepted <= is_byte;
      r_rd_hit   <= rd_hit;
    end
  end

  // The state registers hold exactly the post-transaction values while a result waits.
  assign rsp.valid          = r_valid;
  assign rsp.accepted       = r_accepted;
  assign rsp.frame_held     = pending;
  assign rsp.locked_channel = owner;
  assign rsp.frame_command  = sel_command;
  assign rsp.frame_length   = sel_length;
  assign rsp.read_data      = r_rd_hit ? rd_q : 8'd0;
  assign rsp.received_total = total;

  `DCFR_ASSERT_IMPL(a_one_lane, clk, rst, 1'b1, $onehot0(lane_take))
  `DCFR_ASSERT_IMPL(a_pending_locked, clk, rst, pending, owner != LOCK_NONE)
  `DCFR_ASSERT_NEXT(a_good_sets_pending, clk, rst, adv && any_good, pending)
  `DCFR_ASSERT_IMPL(a_write_from_byte, clk, rst, wr_en, is_byte)

endmodule

FILE: rtl/dual_channel_frame_receiver_crc16.sv
// Dual-channel frame receiver with CRC-16/MODBUS checking. Each transaction on req
// is one of: a received byte with its channel, a payload read by index, a frame
// release, or a restart. Every transaction yields exactly one transaction on rsp,
// carrying the status after it: whether a byte was taken, whether a checked frame
// is pending, the locked channel with its frame command and length, the payload
// byte read, and a wrapping count of parsed bytes. A frame is 0x55 0xAA, command,
// length (at most PAYLOAD_MAX, else the frame is dropped), payload, and the CRC low
// byte first; the CRC runs over command, length and payload. The first good frame
// locks the block to its channel and bytes from the other channel are then dropped;
// while a frame is pending, received bytes are refused (accepted low) until a
// release. The block takes one transaction per clock cycle when rsp is ready. A
// request passes through the decode register and then the head of the
// two-entry queue, where the execute stage updates the deframers, writes or reads
// the payload memory and loads the result register that drives rsp. While rsp
// stalls, the result register holds, then the queue and the decode register fill,
// and req.ready falls.
// The payload memory holds CHANNEL_COUNT * PAYLOAD_MAX bytes with one write and
// one registered read port; it is not cleared, so reading an entry that has not
// been written since reset or restart returns an undefined byte.
module dual_channel_frame_receiver_crc16
  import dcfr_pkg::*;
#(
  parameter int PAYLOAD_MAX   = 128,
  parameter int CHANNEL_COUNT = 2
) (
  input  logic       clk,
  input  logic       rst,
  dcfr_in_if.sink    req,
  dcfr_out_if.source rsp
);

  // Front end to queue.
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;

  // Queue to back end.
  logic pop_valid;
  logic pop;
  cmd_t pop_cmd;

  // The front end registers and classifies each transaction: operation, whether the
  // channel exists and whether the read index falls inside the payload store.
  dcfr_front #(
    .PAYLOAD_MAX   (PAYLOAD_MAX),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // A short queue lets the front end keep accepting while the back end waits on rsp.
  dcfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  // The back end owns the deframer lanes, the lock, the pending flag, the payload
  // memory and the result register.
  dcfr_back #(
    .PAYLOAD_MAX   (PAYLOAD_MAX),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_cmd   (pop_cmd),
    .q_pop   (pop),
    .rsp     (rsp)
  );

endmodule
